// ===== design/mhpq_pkg.sv =====
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

  localparam int PRIO_W       = 4;
  localparam int TAG_W        = 16;
  localparam int DEF_CAPACITY = 64;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

endpackage

// ===== design/max_heap_priority_queue.sv =====
// Binary max-heap priority queue with a sequenced sift over a heap memory.
//
// Usage: present operation, priority_req and tag and raise start while busy
// is low; that edge accepts the command beat. The block then raises busy and
// walks the heap one level at a time through a single-port-write,
// dual-port-read memory with registered read data. Each level passes through
// a read state, which issues the read of the parent or of both children, and
// then a compare state, which compares priorities and writes the displaced
// entry down (or up) into the hole. An insert climbs the new entry until it
// reaches the root or a parent that is not smaller; a remove moves the last
// entry to the root and sinks it until it reaches a leaf or no child is
// greater. Commands that fail (insert when full, remove when empty) and a
// remove that empties the queue go straight to the done state without
// walking the heap.
// The result beat is shown for exactly one cycle with done high; the receiver
// cannot hold it off, so nothing waits on the output side. busy drops in the
// cycle after done. Reset empties the queue at once; the heap memory itself is
// never cleared because only entries below the count are ever used.
module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              operation,
  input  logic [PRIO_W-1:0] priority_req,
  input  logic [TAG_W-1:0]  tag,
  output logic              done,
  output logic              ok,
  output logic [PRIO_W-1:0] removed_priority,
  output logic [TAG_W-1:0]  removed_tag,
  output logic [PRIO_W-1:0] head_priority,
  output logic [TAG_W-1:0]  head_tag,
  output logic [CW-1:0]     entry_count
);

  // Child indexes need two bits beyond the address so they can be compared
  // against the count without wrapping.
  localparam int IW = AW + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UP    = 3'd1;
  localparam logic [2:0] S_UPCMP = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_DN    = 3'd4;
  localparam logic [2:0] S_DNCMP = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] pos, pos_next;
  entry_t        mov, mov_next;
  entry_t        head_reg;
  entry_t        removed, removed_next;
  logic          ok_r, ok_next;
  logic          op_r;

  // Heap memory ports.
  entry_t        mem [CAPACITY];
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr_a, raddr_b;
  entry_t        rd_a, rd_b;

  logic          accept;
  logic [AW-1:0] parent;
  logic [IW-1:0] left_idx, right_idx;
  logic          take_right;
  entry_t        child;
  logic [AW-1:0] child_pos;

  assign accept    = start && !busy;
  assign parent    = (pos - AW'(1)) >> 1;
  assign left_idx  = {1'b0, pos, 1'b1};
  assign right_idx = left_idx + IW'(1);

  // Right child wins only when it exists and is strictly greater.
  assign take_right = (right_idx < IW'(count)) && (rd_b.prio > rd_a.prio);
  assign child      = take_right ? rd_b : rd_a;
  assign child_pos  = take_right ? AW'(right_idx) : AW'(left_idx);

  always_comb begin
    state_next   = state;
    count_next   = count;
    pos_next     = pos;
    mov_next     = mov;
    removed_next = removed;
    ok_next      = ok_r;
    we           = 1'b0;
    waddr        = pos;
    wdata        = mov;
    // In idle the last entry is read ahead so a remove finds it next cycle.
    raddr_a      = AW'(count - CW'(1));
    raddr_b      = AW'(right_idx);
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          removed_next = '0;
          ok_next      = 1'b0;
          state_next   = S_DONE;
          if (operation == OP_INSERT) begin
            if (count < CW'(CAPACITY)) begin
              ok_next    = 1'b1;
              pos_next   = AW'(count);
              mov_next   = {priority_req, tag};
              count_next = count + CW'(1);
              state_next = S_UP;
            end
          end else if (count != '0) begin
            ok_next      = 1'b1;
            removed_next = head_reg;
            count_next   = count - CW'(1);
            pos_next     = '0;
            if (count != CW'(1)) begin
              state_next = S_LOAD;
            end
          end
        end
      end
      S_UP: begin
        // At the root the climb ends; otherwise fetch the parent.
        raddr_a = parent;
        if (pos == '0) begin
          we         = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_UPCMP;
        end
      end
      S_UPCMP: begin
        we = 1'b1;
        if (mov.prio > rd_a.prio) begin
          wdata      = rd_a;
          pos_next   = parent;
          state_next = S_UP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_LOAD: begin
        mov_next   = rd_a;
        state_next = S_DN;
      end
      S_DN: begin
        raddr_a = AW'(left_idx);
        if (left_idx >= IW'(count)) begin
          we         = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_DNCMP;
        end
      end
      S_DNCMP: begin
        we = 1'b1;
        if (mov.prio < child.prio) begin
          wdata      = child;
          pos_next   = child_pos;
          state_next = S_DN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  // The root is mirrored in a register so the head and a remove need no read.
  always_ff @(posedge clk) begin
    if (we && (waddr == '0)) begin
      head_reg <= wdata;
    end
    pos     <= pos_next;
    mov     <= mov_next;
    removed <= removed_next;
    if (accept) begin
      op_r <= operation;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ok_r  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ok_r  <= ok_next;
    end
  end

  assign busy             = (state != S_IDLE);
  assign done             = (state == S_DONE);
  assign ok               = ok_r;
  assign removed_priority = removed.prio;
  assign removed_tag      = removed.tag;
  assign head_priority    = (count != '0) ? head_reg.prio : '0;
  assign head_tag         = (count != '0) ? head_reg.tag : '0;
  assign entry_count      = count;

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // An accepted command occupies the block for at least the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("command accepted without going busy");

  // A result beat lasts one cycle and the block is free right after it.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("done held longer than one cycle");

  // A successful insert always leaves a nonempty queue.
  a_insert_nonempty: assert property (@(posedge clk) disable iff (rst)
    (done && ok_r && (op_r == OP_INSERT)) |-> (count != '0))
    else $error("successful insert left the queue empty");

endmodule
